// ----- rtl/lshist_pkg.sv -----
// shared types, constants and helpers of the latency histogram unit
// no dependencies; every other file imports this package
`default_nettype none

package lshist_pkg;

  localparam int SampleW = 64;
  localparam int ModeW   = 2;
  localparam int SelW    = 4;
  localparam int BinIdxW = 6;
  localparam int TotalW  = 32;

  localparam int NumBins = 16;
  localparam int BinCntW = 32;
  localparam int BinAw   = (NumBins > 1) ? $clog2(NumBins) : 1;
  localparam int NsPerUs = 1000;

  // highest bin whose lower bound NsPerUs << k still fits in a sample
  localparam int MaxBin  = SampleW - $clog2(NsPerUs + 1);

  localparam int QDepth  = 2;
  localparam int QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW   = $clog2(QDepth + 1);

  localparam logic [BinCntW-1:0] CntMax = '1;

  typedef enum logic [ModeW-1:0] {
    ModeRecord = 2'd0,
    ModeRead   = 2'd1,
    ModeClear  = 2'd2,
    ModeIgnore = 2'd3
  } mode_e;

  // classified transaction waiting for the statistics stage
  typedef struct packed {
    mode_e               mode;
    logic [SampleW-1:0]  sample;
    logic [BinIdxW-1:0]  bin;
    logic                in_range;
    logic [SelW-1:0]     sel;
  } qentry_t;

  typedef struct packed {
    logic [SampleW-1:0]  min_latency;
    logic [SampleW-1:0]  max_latency;
    logic [SampleW-1:0]  latency_sum;
    logic [SampleW-1:0]  sample_count;
    logic [BinIdxW-1:0]  bin_index;
    logic                bin_counted;
    logic [TotalW-1:0]   bin_total;
  } result_t;

  function automatic logic [SampleW-1:0] bin_threshold(input int k);
    return SampleW'(NsPerUs) << k;
  endfunction

  function automatic logic [TotalW-1:0] cnt_to_total(input logic [BinCntW-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return w[TotalW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lshist_in_if.sv -----
// input channel of the latency histogram unit: valid/ready plus the sample payload
// depends on lshist_pkg for field widths
`default_nettype none

interface lshist_in_if import lshist_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ModeW-1:0]    mode;
  logic [SampleW-1:0]  latency_value_ns;
  logic [SelW-1:0]     bin_select;

  modport source (output valid, output mode, output latency_value_ns,
                  output bin_select, input ready);
  modport sink   (input valid, input mode, input latency_value_ns,
                  input bin_select, output ready);
endinterface

`default_nettype wire

// ----- rtl/lshist_out_if.sv -----
// result channel of the latency histogram unit: valid/ready plus statistics
// depends on lshist_pkg for field widths
`default_nettype none

interface lshist_out_if import lshist_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SampleW-1:0]  min_latency;
  logic [SampleW-1:0]  max_latency;
  logic [SampleW-1:0]  latency_sum;
  logic [SampleW-1:0]  sample_count;
  logic [BinIdxW-1:0]  bin_index;
  logic                bin_counted;
  logic [TotalW-1:0]   bin_total;

  modport source (output valid, output min_latency, output max_latency,
                  output latency_sum, output sample_count, output bin_index,
                  output bin_counted, output bin_total, input ready);
  modport sink   (input valid, input min_latency, input max_latency,
                  input latency_sum, input sample_count, input bin_index,
                  input bin_counted, input bin_total, output ready);
endinterface

`default_nettype wire

// ----- rtl/lshist_front.sv -----
// front end: accepts input transactions and finds the log2 microsecond bin
// depends on lshist_pkg and lshist_in_if
`default_nettype none

module lshist_front import lshist_pkg::*; (
  lshist_in_if.sink  in_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output qentry_t    push_data_o
);

  logic [MaxBin+1:0]  ge;
  logic [BinIdxW-1:0] bin;

  // us >= 2^k is the same as ns >= 1000 * 2^k, so no divide is needed
  always_comb begin
    ge = '0;
    ge[0] = 1'b1;
    for (int k = 1; k <= MaxBin; k++) begin
      ge[k] = (in_i.latency_value_ns >= bin_threshold(k));
    end
  end

  // thermometer to binary: exactly one position is the top set bit
  always_comb begin
    bin = '0;
    for (int k = 0; k <= MaxBin; k++) begin
      if (ge[k] && !ge[k+1]) begin
        bin = bin | BinIdxW'(k);
      end
    end
  end

  always_comb begin
    push_data_o.mode     = mode_e'(in_i.mode);
    push_data_o.sample   = in_i.latency_value_ns;
    push_data_o.bin      = bin;
    push_data_o.in_range = (int'(bin) < NumBins);
    push_data_o.sel      = in_i.bin_select;
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

`default_nettype wire

// ----- rtl/lshist_queue.sv -----
// short queue between the classifier and the statistics stage
// depends on lshist_pkg
`default_nettype none

module lshist_queue import lshist_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  qentry_t  push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output qentry_t  pop_data_o
);

  qentry_t           entries_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lshist_back.sv -----
// back end: running statistics, bin counters and the result register
// depends on lshist_pkg and lshist_out_if
`default_nettype none

module lshist_back import lshist_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  qentry_t       pop_data_i,
  lshist_out_if.source  out_o
);

  logic [SampleW-1:0]  min_q, min_d;
  logic [SampleW-1:0]  max_q, max_d;
  logic [SampleW-1:0]  sum_q, sum_d;
  logic [SampleW-1:0]  count_q, count_d;
  logic [BinCntW-1:0]  bins_q [NumBins];
  logic [BinCntW-1:0]  bins_d [NumBins];
  logic                out_valid_q, out_valid_d;
  result_t             res_q, res_d;

  logic [BinAw-1:0]    rd_idx;
  logic                rd_ok;
  logic [BinCntW-1:0]  cnt_rd, cnt_inc;
  logic                pop;

  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  // one counter read per transaction: record bin or selected bin
  always_comb begin
    if (pop_data_i.mode == ModeRead) begin
      rd_idx = pop_data_i.sel[BinAw-1:0];
      rd_ok  = (int'(pop_data_i.sel) < NumBins);
    end else begin
      rd_idx = pop_data_i.bin[BinAw-1:0];
      rd_ok  = pop_data_i.in_range;
    end
    cnt_rd  = bins_q[rd_idx];
    cnt_inc = (cnt_rd == CntMax) ? cnt_rd : cnt_rd + 1'b1;
  end

  always_comb begin
    min_d   = min_q;
    max_d   = max_q;
    sum_d   = sum_q;
    count_d = count_q;
    bins_d  = bins_q;
    res_d   = res_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pop) begin
      out_valid_d       = 1'b1;
      res_d.bin_index   = '0;
      res_d.bin_counted = 1'b0;
      res_d.bin_total   = '0;
      case (pop_data_i.mode)
        ModeRecord: begin
          if (pop_data_i.sample < min_q) begin
            min_d = pop_data_i.sample;
          end
          if (pop_data_i.sample > max_q) begin
            max_d = pop_data_i.sample;
          end
          sum_d             = sum_q + pop_data_i.sample;
          count_d           = count_q + 1'b1;
          res_d.bin_index   = pop_data_i.bin;
          res_d.bin_counted = rd_ok;
          if (rd_ok) begin
            bins_d[rd_idx]  = cnt_inc;
            res_d.bin_total = cnt_to_total(cnt_inc);
          end
        end
        ModeRead: begin
          res_d.bin_index = BinIdxW'(pop_data_i.sel);
          if (rd_ok) begin
            res_d.bin_total = cnt_to_total(cnt_rd);
          end
        end
        ModeClear: begin
          min_d   = '1;
          max_d   = '0;
          sum_d   = '0;
          count_d = '0;
          for (int i = 0; i < NumBins; i++) begin
            bins_d[i] = '0;
          end
        end
        default: begin
        end
      endcase
      res_d.min_latency  = min_d;
      res_d.max_latency  = max_d;
      res_d.latency_sum  = sum_d;
      res_d.sample_count = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= '1;
      max_q       <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumBins; i++) begin
        bins_q[i] <= '0;
      end
    end else begin
      min_q       <= min_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      bins_q      <= bins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.min_latency  = res_q.min_latency;
  assign out_o.max_latency  = res_q.max_latency;
  assign out_o.latency_sum  = res_q.latency_sum;
  assign out_o.sample_count = res_q.sample_count;
  assign out_o.bin_index    = res_q.bin_index;
  assign out_o.bin_counted  = res_q.bin_counted;
  assign out_o.bin_total    = res_q.bin_total;

endmodule

`default_nettype wire

// ----- rtl/latency_stats_log2_histogram_unit.sv -----
// top level of the latency monitor: classifier, queue, statistics stage
// depends on lshist_pkg, lshist_in_if, lshist_out_if and the lshist_* modules
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    mode, latency_value_ns, bin_select
//   out_o    out  valid/ready    min/max/sum/count, bin_index, bin_counted, bin_total
//
// one transaction per cycle sustained while out_o is ready; the result passes two registers
// after acceptance (queue entry register, then the result register of the statistics stage)
// the 2-entry queue absorbs output stalls; input ready drops only when it is full
// reset clears all statistics and bin counters at once, no clearing pass
`default_nettype none

module latency_stats_log2_histogram_unit import lshist_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  lshist_in_if.sink     in_i,
  lshist_out_if.source  out_o
);

  logic     push_valid, push_ready;
  qentry_t  push_data;
  logic     pop_valid, pop_ready;
  qentry_t  pop_data;

  lshist_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  lshist_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  lshist_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
